// ===== design/rrjs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrjs_pkg
// Shared types and codes of the round robin join scheduler.
// ----------------------------------------------------------------------------
package rrjs_pkg;

  localparam int unsigned TaskSlotsDef = 128;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_WAIT   = 2'd1;
  localparam logic [1:0] REQ_EXIT   = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;
  localparam logic [1:0] STS_NORUN   = 2'd3;

  localparam logic [1:0] SLOT_READY   = 2'd0;
  localparam logic [1:0] SLOT_WAITING = 2'd1;
  localparam logic [1:0] SLOT_DONE    = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] target_task;
  } rrjs_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] running_task;
    logic [6:0] new_handle;
    logic       switched;
  } rrjs_res_t;

endpackage

// ===== design/round_robin_join_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_join_scheduler
// Task slot table with create, join-wait and exit requests and a round robin
// pick of the next runnable slot. Slot state and join target share one RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------
//  in      | input     | in_valid_i / in_stall_o   | rrjs_req_t
//  out     | output    | out_valid_o / out_stall_i | rrjs_res_t
//
//  Create, invalid handle and unused codes go from the execute state to the
//  result; a wait first reads its target slot and, if that target is done,
//  returns. A blocking wait and an exit then run the scan, which takes one
//  RAM read per slot plus one more for the join target of a waiting slot.
//  One request is in work at a time; in_stall_o is high until it finishes.
//  Reset needs no clearing pass: slots beyond slot_count are written on
//  create before any read, and slot 0 reads as ready until first written.
//  A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module round_robin_join_scheduler
  import rrjs_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rrjs_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rrjs_res_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
  localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned WRD_W = IDX_W + 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_TGT   = 7'b0000100,
    S_SCAN0 = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_JOIN  = 7'b0100000,
    S_FIN   = 7'b1000000
  } fsm_e;

  fsm_e             state_q, state_d;
  rrjs_req_t        req_q, req_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] old_q, old_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [1:0]       sts_q, sts_d;
  logic [6:0]       hnd_q, hnd_d;
  logic             s0_wr_q;
  logic             rd0_q;
  logic             out_valid_q;
  rrjs_res_t        out_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [WRD_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [WRD_W-1:0] ram_rdata;
  logic [WRD_W-1:0] rword;
  logic [1:0]       rstate;
  logic [IDX_W-1:0] rjoin;
  logic             out_load;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(i) + 1'b1;
    if (nx >= n) begin
      return '0;
    end
    return IDX_W'(nx);
  endfunction

  rrjs_ram #(
    .WIDTH(WRD_W),
    .DEPTH(TASK_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rword  = (rd0_q && !s0_wr_q) ? '0 : ram_rdata;
  assign rstate = rword[WRD_W-1:IDX_W];
  assign rjoin  = rword[IDX_W-1:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    cur_d     = cur_q;
    old_d     = old_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    k_d       = k_q;
    sts_d     = sts_q;
    hnd_d     = hnd_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    ram_raddr = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          old_d   = cur_q;
          sts_d   = STS_OK;
          hnd_d   = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        case (req_q.req_type)
          REQ_CREATE: begin
            if (cnt_q >= CNT_W'(TASK_SLOTS)) begin
              sts_d = STS_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = IDX_W'(cnt_q);
              ram_wdata = {SLOT_READY, {IDX_W{1'b0}}};
              hnd_d     = 7'(cnt_q);
              cnt_d     = cnt_q + 1'b1;
            end
          end
          REQ_WAIT: begin
            if (CMP_W'(req_q.target_task) >= CMP_W'(cnt_q)) begin
              sts_d = STS_INVALID;
            end else begin
              ram_raddr = IDX_W'(req_q.target_task);
              state_d   = S_TGT;
            end
          end
          REQ_EXIT: begin
            ram_we    = 1'b1;
            ram_wdata = {SLOT_DONE, {IDX_W{1'b0}}};
            state_d   = S_SCAN0;
          end
          default: begin
          end
        endcase
      end
      S_TGT: begin
        if (rstate == SLOT_DONE) begin
          state_d = S_FIN;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {SLOT_WAITING, IDX_W'(req_q.target_task)};
          state_d   = S_SCAN0;
        end
      end
      S_SCAN0: begin
        idx_d     = next_idx(cur_q, cnt_q);
        ram_raddr = idx_d;
        k_d       = '0;
        state_d   = S_CHK;
      end
      S_CHK, S_JOIN: begin
        if (state_q == S_CHK && rstate == SLOT_READY) begin
          cur_d   = idx_q;
          state_d = S_FIN;
        end else if (state_q == S_CHK && rstate == SLOT_WAITING) begin
          ram_raddr = rjoin;
          state_d   = S_JOIN;
        end else if (state_q == S_JOIN && rstate == SLOT_DONE) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = {SLOT_READY, {IDX_W{1'b0}}};
          cur_d     = idx_q;
          state_d   = S_FIN;
        end else if (k_q + 1'b1 == cnt_q) begin
          sts_d   = STS_NORUN;
          state_d = S_FIN;
          if (req_q.req_type == REQ_WAIT) begin
            ram_we    = 1'b1;
            ram_wdata = {SLOT_READY, {IDX_W{1'b0}}};
          end
        end else begin
          idx_d     = next_idx(idx_q, cnt_q);
          ram_raddr = idx_d;
          k_d       = k_q + 1'b1;
          state_d   = S_CHK;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      cnt_q       <= CNT_W'(1);
      s0_wr_q     <= 1'b0;
      rd0_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      rd0_q   <= (ram_raddr == '0);
      if (ram_we && ram_waddr == '0) begin
        s0_wr_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    old_q <= old_d;
    idx_q <= idx_d;
    k_q   <= k_d;
    sts_q <= sts_d;
    hnd_q <= hnd_d;
    if (out_load) begin
      out_q.status       <= sts_q;
      out_q.running_task <= 7'(cur_q);
      out_q.new_handle   <= hnd_q;
      out_q.switched     <= (cur_q != old_q);
    end
  end

endmodule

// ===== design/rrjs_ram.sv =====
// ----------------------------------------------------------------------------
// rrjs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrjs_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
